### sv/mdpe_pkg.sv
`timescale 1ns / 1ps

package mdpe_pkg;

   localparam int CHANNELS_DEFAULT  = 8;
   localparam int TIME_BITS_DEFAULT = 32;

   localparam int CHAN_W    = 3;
   localparam int NOW_W     = 32;
   localparam int DEB_W     = 16;
   localparam int MODES_W   = 16;
   localparam int INVERT_W  = 8;
   localparam int DEB_REG_W = 64;
   localparam int CSR_W     = 64;
   localparam int CSR_IDX_W = 2;
   localparam int REQ_W     = 40;
   localparam int RSP_W     = 8;

   localparam logic [CSR_IDX_W-1:0] REG_MODES    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INVERT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DEB_LOW  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DEB_HIGH = 2'd3;

   localparam logic [1:0] MODE_INPUT  = 2'd0;
   localparam logic [1:0] MODE_FLAG   = 2'd1;
   localparam logic [1:0] MODE_OUTPUT = 2'd2;
   localparam logic [1:0] MODE_OFF    = 2'd3;

   localparam logic ACT_TICK = 1'b0;
   localparam logic ACT_SET  = 1'b1;

   typedef struct packed {
      logic [1:0]       mode;
      logic             invert;
      logic [DEB_W-1:0] deb_ms;
   } chan_cfg_type;

   typedef struct packed {
      logic changed;
      logic rising;
      logic level_high;
      logic stable_state;
      logic bit_write;
      logic bit_value;
      logic pin_write;
      logic pin_value;
   } result_type;

endpackage

### sv/mdpe_csr.sv
`timescale 1ns / 1ps

module mdpe_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wen,
   input  logic [mdpe_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mdpe_pkg::CSR_W-1:0]          csr_wdata,
   input  logic [mdpe_pkg::CHAN_W-1:0]         sel_channel,
   output mdpe_pkg::chan_cfg_type              sel_cfg
);

   logic [mdpe_pkg::MODES_W-1:0]   modes_ff;
   logic [mdpe_pkg::INVERT_W-1:0]  invert_ff;
   logic [mdpe_pkg::DEB_REG_W-1:0] deb_low_ff;
   logic [mdpe_pkg::DEB_REG_W-1:0] deb_high_ff;
   logic [mdpe_pkg::DEB_REG_W-1:0] deb_reg;

   always_ff @(posedge clock) begin
      if (reset) begin
         modes_ff    <= '0;
         invert_ff   <= '0;
         deb_low_ff  <= '0;
         deb_high_ff <= '0;
      end else if (csr_wen) begin
         case (csr_index)
            mdpe_pkg::REG_MODES: begin
               modes_ff <= csr_wdata[mdpe_pkg::MODES_W-1:0];
            end
            mdpe_pkg::REG_INVERT: begin
               invert_ff <= csr_wdata[mdpe_pkg::INVERT_W-1:0];
            end
            mdpe_pkg::REG_DEB_LOW: begin
               deb_low_ff <= csr_wdata;
            end
            mdpe_pkg::REG_DEB_HIGH: begin
               deb_high_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // channels zero to three live in the low register
   assign deb_reg = sel_channel[2] ? deb_high_ff : deb_low_ff;

   always_comb begin
      sel_cfg.mode   = modes_ff[{sel_channel, 1'b0} +: 2];
      sel_cfg.invert = invert_ff[sel_channel];
      sel_cfg.deb_ms = deb_reg[{sel_channel[1:0], 4'b0000} +: mdpe_pkg::DEB_W];
   end

endmodule

### sv/mdpe_qualify.sv
`timescale 1ns / 1ps

module mdpe_qualify #(
   parameter int CHANNELS  = mdpe_pkg::CHANNELS_DEFAULT,
   parameter int TIME_BITS = mdpe_pkg::TIME_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          update,
   input  logic                          item_action,
   input  logic [mdpe_pkg::CHAN_W-1:0]   item_channel,
   input  logic [TIME_BITS-1:0]          item_now,
   input  logic                          item_pin,
   input  logic                          item_flag,
   input  logic                          item_setv,
   input  mdpe_pkg::chan_cfg_type        cfg,
   output mdpe_pkg::result_type          result
);

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   logic                 comm_ff  [0:CHANNELS-1];
   logic                 samp_ff  [0:CHANNELS-1];
   logic [TIME_BITS-1:0] stamp_ff [0:CHANNELS-1];
   logic                 armed_ff [0:CHANNELS-1];

   logic [IDX_W-1:0]     idx;
   logic                 old_comm;
   logic                 cur_samp;
   logic [TIME_BITS-1:0] cur_stamp;
   logic                 cur_armed;
   logic                 comm_in;
   logic                 samp_in;
   logic [TIME_BITS-1:0] stamp_in;
   logic                 armed_in;
   logic                 pin_lvl;
   logic [TIME_BITS-1:0] stamp_sel;
   logic [TIME_BITS-1:0] elapsed;
   logic                 timed_out;
   logic                 is_out;
   logic                 level;
   logic                 bw;
   logic                 bv;
   logic                 drive;

   assign idx       = item_channel[IDX_W-1:0];
   assign old_comm  = comm_ff[idx];
   assign cur_samp  = samp_ff[idx];
   assign cur_stamp = stamp_ff[idx];
   assign cur_armed = armed_ff[idx];
   assign pin_lvl   = item_pin ^ cfg.invert;
   assign is_out    = (cfg.mode == mdpe_pkg::MODE_OUTPUT);

   // a fresh input change restarts the timer on this very item
   assign stamp_sel = (item_action == mdpe_pkg::ACT_TICK && cfg.mode == mdpe_pkg::MODE_INPUT &&
                       pin_lvl != cur_samp) ? item_now : cur_stamp;
   assign elapsed   = item_now - stamp_sel;
   assign timed_out = (elapsed >= TIME_BITS'(cfg.deb_ms));

   always_comb begin
      comm_in  = old_comm;
      samp_in  = cur_samp;
      stamp_in = cur_stamp;
      armed_in = cur_armed;
      level    = 1'b0;
      bw       = 1'b0;
      bv       = 1'b0;
      drive    = 1'b0;
      if (item_action == mdpe_pkg::ACT_SET) begin
         if (cfg.mode == mdpe_pkg::MODE_FLAG || cfg.mode == mdpe_pkg::MODE_OUTPUT) begin
            comm_in = item_setv;
            bw      = 1'b1;
            bv      = item_setv;
            drive   = is_out;
         end
      end else begin
         case (cfg.mode)
            mdpe_pkg::MODE_INPUT: begin
               level    = pin_lvl;
               samp_in  = pin_lvl;
               stamp_in = stamp_sel;
               if (pin_lvl != old_comm && timed_out) begin
                  comm_in = pin_lvl;
                  bw      = 1'b1;
                  bv      = pin_lvl;
               end
            end
            mdpe_pkg::MODE_FLAG, mdpe_pkg::MODE_OUTPUT: begin
               level = item_flag;
               // pulse expiry
               if (cfg.deb_ms != '0 && cur_armed && timed_out) begin
                  level    = 1'b0;
                  armed_in = 1'b0;
                  comm_in  = 1'b0;
                  bw       = 1'b1;
                  bv       = 1'b0;
                  drive    = is_out;
               end
               if (level != comm_in) begin
                  armed_in = level;
                  if (level) begin
                     stamp_in = item_now;
                  end
                  comm_in = level;
                  bw      = 1'b1;
                  bv      = level;
                  drive   = is_out;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      result.changed      = (comm_in != old_comm);
      result.rising       = (comm_in != old_comm) & comm_in;
      result.level_high   = level;
      result.stable_state = comm_in;
      result.bit_write    = bw;
      result.bit_value    = bv;
      result.pin_write    = drive;
      result.pin_value    = drive & (comm_in ^ cfg.invert);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            comm_ff[i]  <= 1'b0;
            samp_ff[i]  <= 1'b0;
            stamp_ff[i] <= '0;
            armed_ff[i] <= 1'b0;
         end
      end else if (update) begin
         comm_ff[idx]  <= comm_in;
         samp_ff[idx]  <= samp_in;
         stamp_ff[idx] <= stamp_in;
         armed_ff[idx] <= armed_in;
      end
   end

endmodule

### sv/multichannel_debounce_pulse_events.sv
`timescale 1ns / 1ps

// Per-channel debounce and monostable pulse qualifier, up to eight channels.
// req_ channel: one word per item, naming a channel and a millisecond time;
// req_tuser selects a periodic tick or a software set-state.
// rsp_ channel: one word per item with edge, level, status bit write-back and
// pin drive. An item for a channel at or beyond CHANNELS gives no word.
// csr_ port: register writes (modes, invert mask, two debounce time banks),
// taken at any edge with csr_wen high; write only while the block is idle.
// A word accepted is held in the input register while it is processed, and its
// result is registered into the output register that drives rsp_.
// Throughput: one item per cycle while rsp_ does not stall; the per-channel
// state is read and written back in the same cycle, so consecutive items on
// one channel see each other's updates without delay.
// Stall: while rsp_tready is low the result holds; one more item may wait in
// the input register, after which req_tready drops.
// Reset: zeroes all channel state, the CSR registers and both valid flags;
// no clearing pass is needed and an item may be accepted right after reset.
module multichannel_debounce_pulse_events #(
   parameter int CHANNELS  = mdpe_pkg::CHANNELS_DEFAULT,
   parameter int TIME_BITS = mdpe_pkg::TIME_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // channel, now_ms, pin_level, flag_level, set_value, zero fill
   input  logic [mdpe_pkg::REQ_W-1:0]        req_tdata,
   // action
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // changed, rising, level_high, stable_state, bit_write, bit_value,
   // pin_write, pin_value
   output logic [mdpe_pkg::RSP_W-1:0]        rsp_tdata,
   input  logic                              csr_wen,
   input  logic [mdpe_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mdpe_pkg::CSR_W-1:0]        csr_wdata
);

   logic                              s1_valid_ff;
   logic                              s1_valid_in;
   logic                              s1_action_ff;
   logic [mdpe_pkg::CHAN_W-1:0]       s1_channel_ff;
   logic [TIME_BITS-1:0]              s1_now_ff;
   logic                              s1_pin_ff;
   logic                              s1_flag_ff;
   logic                              s1_setv_ff;
   logic                              rsp_valid_ff;
   logic                              rsp_valid_in;
   logic [mdpe_pkg::RSP_W-1:0]        rsp_data_ff;
   logic                              advance;
   logic                              in_range;
   logic                              update;
   mdpe_pkg::chan_cfg_type            cfg;
   mdpe_pkg::result_type              result;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || advance;
   assign in_range   = ({1'b0, s1_channel_ff} < 4'(CHANNELS));
   assign update     = s1_valid_ff && advance && in_range;

   assign s1_valid_in  = req_tready ? req_tvalid : s1_valid_ff;
   assign rsp_valid_in = advance ? (s1_valid_ff && in_range) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_action_ff  <= req_tuser;
         s1_channel_ff <= req_tdata[2:0];
         s1_now_ff     <= req_tdata[3 +: TIME_BITS];
         s1_pin_ff     <= req_tdata[35];
         s1_flag_ff    <= req_tdata[36];
         s1_setv_ff    <= req_tdata[37];
      end
   end

   always_ff @(posedge clock) begin
      if (update) begin
         rsp_data_ff <= {result.pin_value, result.pin_write, result.bit_value,
                         result.bit_write, result.stable_state, result.level_high,
                         result.rising, result.changed};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   mdpe_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wen     (csr_wen),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .sel_channel (s1_channel_ff),
      .sel_cfg     (cfg)
   );

   mdpe_qualify #(
      .CHANNELS  (CHANNELS),
      .TIME_BITS (TIME_BITS)
   ) u_qualify (
      .clock        (clock),
      .reset        (reset),
      .update       (update),
      .item_action  (s1_action_ff),
      .item_channel (s1_channel_ff),
      .item_now     (s1_now_ff),
      .item_pin     (s1_pin_ff),
      .item_flag    (s1_flag_ff),
      .item_setv    (s1_setv_ff),
      .cfg          (cfg),
      .result       (result)
   );

   // an item for a missing channel never produces a word
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && advance && !in_range) |=> !rsp_tvalid)
      else $error("result produced for out of range channel");

   // the input side only stalls with both stages full
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (s1_valid_ff && rsp_valid_ff && !rsp_tready))
      else $error("input stalled with room in pipeline");

   // write-back value and drive value only with their strobes
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata[4] || !rsp_tdata[5]) && (rsp_tdata[6] || !rsp_tdata[7])))
      else $error("value reported without write strobe");

   // a rising edge always leaves the committed level high
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[1]) |-> (rsp_tdata[0] && rsp_tdata[3]))
      else $error("rising edge inconsistent with committed level");

endmodule
